// File: rtl/epwc_pkg.sv
package epwc_pkg;

   // Ring depth. It must be a power of two so that the pointers wrap on their own.
   localparam int FIFO_DEPTH = 128;
   localparam int PTR_W      = $clog2(FIFO_DEPTH);
   localparam int COUNT_W    = 7;
   localparam int TS_W       = 64;
   localparam int WIN_W      = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [WIN_W-1:0] MIN_WIDTH_RESET = 32'd58000;
   localparam logic [WIN_W-1:0] MAX_WIDTH_RESET = 32'd60000000;

   // Register index, taken from paddr bit 2.
   localparam logic REG_MIN_WIDTH = 1'b0;
   localparam logic REG_MAX_WIDTH = 1'b1;

   localparam logic FUNC_EDGE = 1'b0;
   localparam logic FUNC_READ = 1'b1;

   localparam logic LEVEL_RISE = 1'b1;

   typedef enum logic [2:0] {
      ST_RISE   = 3'd0,
      ST_STORED = 3'd1,
      ST_FULL   = 3'd2,
      ST_WINDOW = 3'd3,
      ST_ORPHAN = 3'd4,
      ST_POPPED = 3'd5,
      ST_EMPTY  = 3'd6
   } status_type;

   typedef logic [PTR_W-1:0] ptr_type;

   typedef struct packed {
      logic            func;
      logic            echo_level;
      logic [TS_W-1:0] timestamp_ns;
   } req_word_type;

   typedef struct packed {
      status_type         status;
      logic [TS_W-1:0]    pulse_width_ns;
      logic [TS_W-1:0]    pop_data;
      logic [COUNT_W-1:0] fifo_count;
   } rsp_word_type;

endpackage

// File: rtl/echo_pulse_width_capture_top.sv
// A word accepted on the request side passes the first result stage and then the output
// register before rsp_valid offers its result word. Throughput: one word per cycle
// unless rsp_stall holds the result stages; each word takes one subtract, two compares and
// at most one access of the width memory, which has one write and one registered read port.
// Reset (synchronous, active high): the block is disarmed, the ring is empty and the
// window registers return to 58000 ns and 60000000 ns. The width memory is not cleared.
module echo_pulse_width_capture_top (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  epwc_pkg::req_word_type                 req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output epwc_pkg::rsp_word_type                 rsp_data,
   input  logic                                   psel,
   input  logic                                   penable,
   input  logic                                   pwrite,
   input  logic [epwc_pkg::CSR_ADDR_W-1:0]        paddr,
   input  logic [epwc_pkg::CSR_DATA_W-1:0]        pwdata,
   output logic [epwc_pkg::CSR_DATA_W-1:0]        prdata,
   output logic                                   pready
);
   import epwc_pkg::*;

   // Configuration registers. The register is selected by address bit 2 only.
   logic [WIN_W-1:0] min_width_ff, min_width_in;
   logic [WIN_W-1:0] max_width_ff, max_width_in;
   logic             csr_write;
   logic             csr_index;

   assign pready    = 1'b1;
   assign csr_index = paddr[2];
   assign csr_write = psel & penable & pwrite & pready;

   always_comb begin
      min_width_in = min_width_ff;
      max_width_in = max_width_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_MIN_WIDTH: min_width_in = pwdata;
            REG_MAX_WIDTH: max_width_in = pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_MIN_WIDTH: prdata = min_width_ff;
         REG_MAX_WIDTH: prdata = max_width_ff;
         default:       prdata = '0;
      endcase
   end

   // Measurement state: the rise record and the ring pointers. Everything
   // about a word is decided in the cycle it is accepted, so the next word
   // already sees the updated state.
   logic            armed_ff, armed_in;
   logic [TS_W-1:0] rise_time_ff, rise_time_in;
   ptr_type         rd_ptr_ff, rd_ptr_in;
   ptr_type         wr_ptr_ff, wr_ptr_in;

   logic            req_accept;
   logic            is_read;
   logic            fifo_empty;
   logic            fifo_full;
   ptr_type         rd_ptr_inc;
   ptr_type         wr_ptr_inc;
   logic [TS_W-1:0] edge_width;
   logic            in_window;
   logic            do_push;
   logic            do_pop;
   status_type      status_in;
   logic [TS_W-1:0] width_in;

   assign req_accept = req_valid & ~req_stall;
   assign is_read    = (req_data.func == FUNC_READ);
   assign rd_ptr_inc = rd_ptr_ff + 1'b1;
   assign wr_ptr_inc = wr_ptr_ff + 1'b1;
   assign fifo_empty = (rd_ptr_ff == wr_ptr_ff);
   // One slot always stays free, so the ring is full one step short of wrapping.
   assign fifo_full  = (wr_ptr_inc == rd_ptr_ff);

   // The width is the modular difference, so a timestamp wrap needs no care.
   assign edge_width = req_data.timestamp_ns - rise_time_ff;
   assign in_window  = (edge_width > {{(TS_W-WIN_W){1'b0}}, min_width_ff}) &&
                       (edge_width < {{(TS_W-WIN_W){1'b0}}, max_width_ff});

   always_comb begin
      armed_in     = armed_ff;
      rise_time_in = rise_time_ff;
      rd_ptr_in    = rd_ptr_ff;
      wr_ptr_in    = wr_ptr_ff;
      do_push      = 1'b0;
      do_pop       = 1'b0;
      status_in    = ST_RISE;
      width_in     = '0;
      priority if (is_read) begin
         if (fifo_empty) begin
            status_in = ST_EMPTY;
         end else begin
            do_pop    = 1'b1;
            rd_ptr_in = rd_ptr_inc;
            status_in = ST_POPPED;
         end
      end else if (req_data.echo_level == LEVEL_RISE) begin
         // A rise while armed simply restarts the measurement.
         rise_time_in = req_data.timestamp_ns;
         armed_in     = 1'b1;
         status_in    = ST_RISE;
      end else if (!armed_ff) begin
         status_in = ST_ORPHAN;
      end else begin
         // Any fall on an armed block ends the measurement, stored or not.
         width_in     = edge_width;
         armed_in     = 1'b0;
         rise_time_in = '0;
         if (!in_window) begin
            status_in = ST_WINDOW;
         end else if (fifo_full) begin
            status_in = ST_FULL;
         end else begin
            do_push   = 1'b1;
            wr_ptr_in = wr_ptr_inc;
            status_in = ST_STORED;
         end
      end
   end

   // Width memory with one write port and one registered read port. A push
   // and a pop never come from the same word, and a word that pops reads
   // memory written by earlier words at earlier edges.
   logic [TS_W-1:0] width_mem [FIFO_DEPTH];
   logic [TS_W-1:0] mem_rd_ff;

   always_ff @(posedge clock) begin
      if (req_accept && do_push) begin
         width_mem[wr_ptr_ff] <= edge_width;
      end
      if (req_accept && do_pop) begin
         mem_rd_ff <= width_mem[rd_ptr_ff];
      end
   end

   // Two result stages: the first holds what was decided at accept time while
   // the memory read completes, the second is the output register. The first
   // stage lets a new word in while a finished result waits to be taken.
   logic               p_valid_ff, p_valid_in;
   status_type         p_status_ff;
   logic [TS_W-1:0]    p_width_ff;
   logic [COUNT_W-1:0] p_count_ff;
   logic               p_pop_ff;
   logic               p_move;
   logic               o_valid_ff, o_valid_in;
   rsp_word_type       o_data_ff, o_data_in;

   assign p_move     = p_valid_ff & (~o_valid_ff | ~rsp_stall);
   assign req_stall  = p_valid_ff & ~p_move;
   assign p_valid_in = req_accept | (p_valid_ff & ~p_move);
   assign o_valid_in = p_move | (o_valid_ff & rsp_stall);

   always_comb begin
      o_data_in.status         = p_status_ff;
      o_data_in.pulse_width_ns = p_width_ff;
      o_data_in.pop_data       = p_pop_ff ? mem_rd_ff : '0;
      o_data_in.fifo_count     = p_count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_width_ff <= MIN_WIDTH_RESET;
         max_width_ff <= MAX_WIDTH_RESET;
         armed_ff     <= 1'b0;
         rd_ptr_ff    <= '0;
         wr_ptr_ff    <= '0;
         p_valid_ff   <= 1'b0;
         o_valid_ff   <= 1'b0;
      end else begin
         min_width_ff <= min_width_in;
         max_width_ff <= max_width_in;
         p_valid_ff   <= p_valid_in;
         o_valid_ff   <= o_valid_in;
         if (req_accept) begin
            armed_ff  <= armed_in;
            rd_ptr_ff <= rd_ptr_in;
            wr_ptr_ff <= wr_ptr_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rise_time_ff <= rise_time_in;
         p_status_ff  <= status_in;
         p_width_ff   <= width_in;
         p_count_ff   <= COUNT_W'(ptr_type'(wr_ptr_in - rd_ptr_in));
         p_pop_ff     <= do_pop;
      end
      if (p_move) begin
         o_data_ff <= o_data_in;
      end
   end

   assign rsp_valid = o_valid_ff;
   assign rsp_data  = o_data_ff;

   // A full ring never takes another width.
   assert property (@(posedge clock) disable iff (reset)
      fifo_full |=> (wr_ptr_ff == $past(wr_ptr_ff)))
      else $error("write pointer advanced on a full ring");

   // A read on an empty ring leaves the read pointer alone.
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && is_read && fifo_empty) |=> (rd_ptr_ff == $past(rd_ptr_ff)))
      else $error("read pointer advanced on an empty ring");

   // Every accepted falling edge leaves the block disarmed.
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && !is_read && req_data.echo_level != LEVEL_RISE) |=> !armed_ff)
      else $error("block still armed after a falling edge");

   // A held first-stage result is neither lost nor overwritten.
   assert property (@(posedge clock) disable iff (reset)
      (p_valid_ff && !p_move) |=> (p_valid_ff && $stable(p_status_ff) && $stable(p_width_ff)))
      else $error("pending result lost in the first stage");

   // A result that leaves the first stage is valid in the output register in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      p_move |=> o_valid_ff)
      else $error("result moved forward without becoming valid");

endmodule
